// ----- hw/rtl/dlp_pkg.sv -----
// Shared types and constants for the descriptor loop parser.
// Used by dlp_cfg, dlp_core, dlp_out_stage and the top level.
package dlp_pkg;

  localparam int unsigned HdrBytes = 2;

  // register indexes, taken from paddr[2]
  localparam logic REG_LOOP_LENGTH = 1'b0;
  localparam logic REG_MATCH_TAG   = 1'b1;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_DEAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  desc_tag;
    logic [7:0]  desc_length;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_offset;
    logic        last_of_descriptor;
    logic [14:0] desc_index;
    logic        tag_match;
    logic        first_match_res;
  } res_t;

endpackage

// ----- hw/rtl/dlp_cfg.sv -----
// APB register file for the descriptor loop parser: loop length and match tag.
// Depends on dlp_pkg for the register indexes.
module dlp_cfg import dlp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] loop_length,
  output logic [7:0]  match_tag
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_length <= '0;
      match_tag   <= '0;
    end else if (wr) begin
      unique case (paddr[2])
        REG_LOOP_LENGTH: loop_length <= pwdata[15:0];
        REG_MATCH_TAG:   match_tag   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LOOP_LENGTH: prdata = {16'd0, loop_length};
      REG_MATCH_TAG:   prdata = {24'd0, match_tag};
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/dlp_core.sv -----
// Input register and parse state machine of the descriptor loop parser.
// Depends on dlp_pkg for phase_t and res_t.
module dlp_core import dlp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        loop_start,
  input  logic [15:0] loop_length,
  input  logic [7:0]  match_tag,
  input  logic        advance,
  output logic        byte_held,
  output logic        hit,
  output res_t        res
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_start;
  logic        fire;

  phase_t      phase, phase_e, phase_next;
  logic [15:0] loop_remaining, rem_e, loop_remaining_next;
  logic [7:0]  held_tag, held_tag_next;
  logic [7:0]  held_length, held_length_next;
  logic [7:0]  payload_count, count_e, payload_count_next;
  logic [14:0] accepted_count, acc_e, accepted_count_next;
  logic        match_seen, seen_e, match_seen_next;
  logic        m;
  logic        last;

  assign byte_stall = in_valid && !advance;
  assign fire       = in_valid && advance;
  assign byte_held  = in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!byte_stall) begin
      in_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte  <= data_byte;
      in_start <= loop_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TAG;
      loop_remaining <= '0;
      held_tag       <= '0;
      held_length    <= '0;
      payload_count  <= '0;
      accepted_count <= '0;
      match_seen     <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      loop_remaining <= loop_remaining_next;
      held_tag       <= held_tag_next;
      held_length    <= held_length_next;
      payload_count  <= payload_count_next;
      accepted_count <= accepted_count_next;
      match_seen     <= match_seen_next;
    end
  end

  always_comb begin
    phase_e = in_start ? PH_TAG      : phase;
    rem_e   = in_start ? loop_length : loop_remaining;
    count_e = in_start ? 8'd0        : payload_count;
    acc_e   = in_start ? 15'd0       : accepted_count;
    seen_e  = in_start ? 1'b0        : match_seen;

    m    = (held_tag == match_tag);
    last = 1'b0;

    phase_next          = phase_e;
    loop_remaining_next = rem_e;
    held_tag_next       = held_tag;
    held_length_next    = held_length;
    payload_count_next  = count_e;
    accepted_count_next = acc_e;
    match_seen_next     = seen_e;

    hit                    = 1'b0;
    res.item_kind          = KIND_HEADER;
    res.desc_tag           = held_tag;
    res.desc_length        = held_length;
    res.payload_byte       = '0;
    res.payload_offset     = '0;
    res.last_of_descriptor = 1'b0;
    res.desc_index         = acc_e;
    res.tag_match          = m;
    res.first_match_res    = m && !seen_e;

    if (rem_e != 16'd0) begin
      loop_remaining_next = rem_e - 16'd1;
      unique case (phase_e)
        PH_TAG: begin
          if (rem_e < 16'(HdrBytes)) begin
            phase_next = PH_DEAD;
          end else begin
            held_tag_next = in_byte;
            phase_next    = PH_LEN;
          end
        end
        PH_LEN: begin
          // fits when tag + length + payload <= bytes left from the tag
          if ({8'd0, in_byte} >= rem_e) begin
            phase_next = PH_DEAD;
          end else begin
            held_length_next       = in_byte;
            payload_count_next     = '0;
            last                   = (in_byte == 8'd0);
            hit                    = 1'b1;
            res.desc_length        = in_byte;
            res.last_of_descriptor = last;
            phase_next             = last ? PH_TAG : PH_PAY;
          end
        end
        PH_PAY: begin
          last                   = ({1'b0, count_e} + 9'd1) >= {1'b0, held_length};
          hit                    = 1'b1;
          res.item_kind          = KIND_PAYLOAD;
          res.payload_byte       = in_byte;
          res.payload_offset     = count_e;
          res.last_of_descriptor = last;
          payload_count_next     = count_e + 8'd1;
          if (last) begin
            phase_next = PH_TAG;
          end
        end
        PH_DEAD: ;
        default: ;
      endcase
      if (hit && last) begin
        accepted_count_next = acc_e + 15'd1;
        match_seen_next     = seen_e | m;
      end
    end
  end

endmodule

// ----- hw/rtl/dlp_out_stage.sv -----
// Result register of the descriptor loop parser with its handshake.
// Depends on dlp_pkg for res_t.
module dlp_out_stage import dlp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_hit,
  input  logic core_valid,
  input  res_t in_res,
  output logic advance,
  output logic result_valid,
  input  logic result_stall,
  output res_t result
);

  assign advance = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= core_valid && in_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_valid && in_hit) begin
      result <= in_res;
    end
  end

endmodule

// ----- hw/rtl/descriptor_loop_tlv_parser_top.sv -----
// Descriptor loop parser: takes one loop byte per cycle and emits a header word
// per descriptor that fits the loop and one word per payload byte. An accepted
// byte's word passes through the input register, then the result register;
// the sustained rate is one byte per cycle, limited only by result_stall.
// Depends on dlp_pkg, dlp_cfg, dlp_core and dlp_out_stage.
module descriptor_loop_tlv_parser_top import dlp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        loop_start,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        item_kind,
  output logic [7:0]  desc_tag,
  output logic [7:0]  desc_length,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_offset,
  output logic        last_of_descriptor,
  output logic [14:0] desc_index,
  output logic        tag_match,
  output logic        first_match_res
);

  logic [15:0] loop_length;
  logic [7:0]  match_tag;
  logic        advance;
  logic        hit;
  logic        core_valid;
  res_t        core_res;
  res_t        result;

  dlp_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .loop_length (loop_length),
    .match_tag   (match_tag)
  );

  dlp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .data_byte   (data_byte),
    .loop_start  (loop_start),
    .loop_length (loop_length),
    .match_tag   (match_tag),
    .advance     (advance),
    .byte_held   (core_valid),
    .hit         (hit),
    .res         (core_res)
  );

  dlp_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .in_hit       (hit),
    .core_valid   (core_valid),
    .in_res       (core_res),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign item_kind          = result.item_kind;
  assign desc_tag           = result.desc_tag;
  assign desc_length        = result.desc_length;
  assign payload_byte       = result.payload_byte;
  assign payload_offset     = result.payload_offset;
  assign last_of_descriptor = result.last_of_descriptor;
  assign desc_index         = result.desc_index;
  assign tag_match          = result.tag_match;
  assign first_match_res    = result.first_match_res;

endmodule

// ----- hw/rtl/dlp_checker.sv -----
// Port-level assertions for the descriptor loop parser top level.
// Depends on dlp_pkg; bound to descriptor_loop_tlv_parser_top below.
module dlp_checker import dlp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic        item_kind,
  input logic [7:0]  desc_length,
  input logic [7:0]  payload_byte,
  input logic [7:0]  payload_offset,
  input logic        last_of_descriptor,
  input logic [14:0] desc_index,
  input logic        tag_match,
  input logic        first_match_res
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(payload_byte) && $stable(desc_index))
    else $error("stalled result word changed");

  a_empty_hdr_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && item_kind == KIND_HEADER && desc_length == 8'd0 |->
      last_of_descriptor)
    else $error("empty descriptor header not marked last");

  a_hdr_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && item_kind == KIND_HEADER |->
      payload_byte == 8'd0 && payload_offset == 8'd0)
    else $error("header word carries payload fields");

  a_first_match: assert property (@(posedge clk) disable iff (rst)
    result_valid && first_match_res |-> tag_match)
    else $error("first match without tag match");

endmodule

bind descriptor_loop_tlv_parser_top dlp_checker u_dlp_checker (
  .clk                (clk),
  .rst                (rst),
  .result_valid       (result_valid),
  .result_stall       (result_stall),
  .item_kind          (item_kind),
  .desc_length        (desc_length),
  .payload_byte       (payload_byte),
  .payload_offset     (payload_offset),
  .last_of_descriptor (last_of_descriptor),
  .desc_index         (desc_index),
  .tag_match          (tag_match),
  .first_match_res    (first_match_res)
);

// ----- sim/descriptor_loop_tlv_parser_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for descriptor_loop_tlv_parser_top: drives loop bytes and APB
// register writes, predicts every header and payload word, and checks them in order.
// Depends on dlp_pkg and the descriptor_loop_tlv_parser_top RTL.
module descriptor_loop_tlv_parser_top_tb;
  import dlp_pkg::*;

  class descriptor_scoreboard;
    logic [15:0] loop_len;
    logic [7:0]  flag_tag;
    logic [15:0] left_in_loop;
    phase_t      phase;
    logic [7:0]  tag_q;
    logic [7:0]  len_q;
    logic [7:0]  pay_cnt;
    logic [14:0] accepted;
    logic        seen_match;
    res_t        due_words[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      loop_len = '0;
      flag_tag = '0;
      left_in_loop = '0;
      phase = PH_TAG;
      tag_q = '0;
      len_q = '0;
      pay_cnt = '0;
      accepted = '0;
      seen_match = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == REG_LOOP_LENGTH) begin
        loop_len = value[15:0];
      end else begin
        flag_tag = value[7:0];
      end
    endfunction

    // returns 1 when the byte was consumed by a live loop
    function bit parse_byte(logic [7:0] b, logic start);
      res_t        w;
      int unsigned r;
      logic        hit;
      if (start) begin
        left_in_loop = loop_len;
        phase = PH_TAG;
        accepted = '0;
        seen_match = 1'b0;
        pay_cnt = '0;
      end
      if (left_in_loop == 0) return 1'b0;
      r = left_in_loop;
      left_in_loop = left_in_loop - 16'd1;
      if (phase == PH_DEAD) return 1'b0;
      w = '0;
      case (phase)
        PH_TAG: begin
          if (r < HdrBytes) begin
            phase = PH_DEAD;
            return 1'b0;
          end
          tag_q = b;
          phase = PH_LEN;
          return 1'b1;
        end
        PH_LEN: begin
          if (int'(b) + HdrBytes > r + 1) begin
            phase = PH_DEAD;
            return 1'b1;
          end
          len_q = b;
          pay_cnt = '0;
          w.item_kind = KIND_HEADER;
          w.last_of_descriptor = (b == 8'd0);
        end
        default: begin
          w.item_kind = KIND_PAYLOAD;
          w.payload_byte = b;
          w.payload_offset = pay_cnt;
          w.last_of_descriptor = (int'(pay_cnt) + 1 >= int'(len_q));
          pay_cnt = pay_cnt + 8'd1;
        end
      endcase
      hit = (tag_q == flag_tag);
      w.desc_tag = tag_q;
      w.desc_length = len_q;
      w.desc_index = accepted;
      w.tag_match = hit;
      w.first_match_res = hit && !seen_match;
      due_words = {due_words, w};
      if (w.last_of_descriptor) begin
        accepted = accepted + 15'd1;
        seen_match = seen_match | hit;
        phase = PH_TAG;
      end else begin
        phase = PH_PAY;
      end
      return 1'b1;
    endfunction

    function int unsigned field_diff(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 0;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      return 1;
    endfunction

    function void check_word(res_t got);
      res_t        w;
      int unsigned bad;
      checked++;
      if (due_words.size() == 0) begin
        errors++;
        $display("%0t: result word expected none, got %h", $time, got);
        return;
      end
      w = due_words.pop_front();
      bad = 0;
      bad += field_diff("item_kind", 32'(w.item_kind), 32'(got.item_kind));
      bad += field_diff("desc_tag", 32'(w.desc_tag), 32'(got.desc_tag));
      bad += field_diff("desc_length", 32'(w.desc_length), 32'(got.desc_length));
      bad += field_diff("payload_byte", 32'(w.payload_byte), 32'(got.payload_byte));
      bad += field_diff("payload_offset", 32'(w.payload_offset),
                        32'(got.payload_offset));
      bad += field_diff("last_of_descriptor", 32'(w.last_of_descriptor),
                        32'(got.last_of_descriptor));
      bad += field_diff("desc_index", 32'(w.desc_index), 32'(got.desc_index));
      bad += field_diff("tag_match", 32'(w.tag_match), 32'(got.tag_match));
      bad += field_diff("first_match_res", 32'(w.first_match_res),
                        32'(got.first_match_res));
      if (bad != 0) errors++;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  data_byte;
  logic        loop_start;
  logic        result_valid;
  logic        result_stall;
  logic        item_kind;
  logic [7:0]  desc_tag;
  logic [7:0]  desc_length;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_offset;
  logic        last_of_descriptor;
  logic [14:0] desc_index;
  logic        tag_match;
  logic        first_match_res;
  res_t        out_word;

  descriptor_scoreboard sb;
  int unsigned live_count;
  bit          paused_once;

  assign out_word = {item_kind, desc_tag, desc_length, payload_byte, payload_offset,
                     last_of_descriptor, desc_index, tag_match, first_match_res};

  descriptor_loop_tlv_parser_top dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .data_byte(data_byte),
    .loop_start(loop_start),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .item_kind(item_kind),
    .desc_tag(desc_tag),
    .desc_length(desc_length),
    .payload_byte(payload_byte),
    .payload_offset(payload_offset),
    .last_of_descriptor(last_of_descriptor),
    .desc_index(desc_index),
    .tag_match(tag_match),
    .first_match_res(first_match_res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    while (!(live_count >= 300 && live_count < 550) && $urandom_range(0, 99) < 22) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    loop_start <= start;
    do @(posedge clk); while (byte_stall);
    if (sb.parse_byte(b, start)) live_count++;
  endtask

  // drop valid and wait until every expected word is out
  task automatic settle();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic run_loop(input int unsigned cap);
    logic [7:0]  seq[$];
    logic [7:0]  t;
    int unsigned left;
    int unsigned d;
    int unsigned mx;
    int unsigned r;
    left = sb.loop_len;
    while (left > 0 && seq.size() < cap) begin
      if (left < HdrBytes) begin
        seq = {seq, 8'($urandom)};
        left = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) t = sb.flag_tag;
        else if (r < 45) t = 8'h00;
        else if (r < 55) t = 8'hFF;
        else t = 8'($urandom);
        seq = {seq, t};
        r = $urandom_range(0, 99);
        if (r < 7 && left - 1 <= 255) begin
          seq = {seq, 8'($urandom_range(left - 1, 255))};
          repeat ($urandom_range(0, 3)) seq = {seq, 8'($urandom)};
          left = 0;
        end else begin
          mx = left - HdrBytes;
          if (mx > 255) mx = 255;
          r = $urandom_range(0, 99);
          if (r < 10) d = mx;
          else if (r < 70) d = $urandom_range(0, mx < 6 ? mx : 6);
          else if (r < 90) d = $urandom_range(0, mx < 40 ? mx : 40);
          else d = $urandom_range(0, mx);
          seq = {seq, 8'(d)};
          repeat (d) seq = {seq, 8'($urandom)};
          left -= d + HdrBytes;
        end
      end
    end
    if (seq.size() == 0 || $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) seq = {seq, 8'($urandom)};
    if (seq.size() > 1 && $urandom_range(0, 99) < 8) begin
      d = $urandom_range(1, seq.size() - 1);
      while (seq.size() > d) void'(seq.pop_back());
    end
    foreach (seq[i]) begin
      if (!paused_once && live_count >= 700) begin
        paused_once = 1'b1;
        settle();
      end
      send_byte(seq[i], i == 0);
    end
  endtask

  // result side: random stall, one long hold-off, one stretch with no stall
  initial begin
    int unsigned hold;
    bit          held_once;
    hold = 0;
    held_once = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) sb.check_word(out_word);
      if (hold > 0) begin
        hold--;
      end else if (!held_once && sb.checked >= 150 && byte_valid) begin
        hold = 400;
        held_once = 1'b1;
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
      end else if (sb.checked >= 600 && sb.checked < 900) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(0, 99) < 22);
      end
    end
  end

  initial begin
    int unsigned r;
    logic [15:0] len;
    sb = new();
    live_count = 0;
    paused_once = 1'b1;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    byte_valid <= 1'b0;
    data_byte <= '0;
    loop_start <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cfg_write(REG_LOOP_LENGTH, 32'd10);
    cfg_write(REG_MATCH_TAG, 32'hFF);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h03, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h02, 1'b1);
    send_byte(8'h00, 1'b0);
    settle();
    cfg_write(REG_LOOP_LENGTH, 32'd3);
    cfg_write(REG_MATCH_TAG, 32'h00);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'hFF, 1'b0);
    settle();
    cfg_write(REG_LOOP_LENGTH, 32'd0);
    send_byte(8'h55, 1'b1);
    settle();
    cfg_write(REG_LOOP_LENGTH, 32'hFFFF);
    send_byte(8'hAB, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h81, 1'b0);

    live_count = 0;
    paused_once = 1'b0;
    while (live_count < 1250) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 5) len = 16'd0;
      else if (r < 10) len = 16'd1;
      else if (r < 15) len = 16'hFFFF;
      else if (r < 25) len = 16'($urandom_range(200, 600));
      else len = 16'($urandom_range(2, 48));
      cfg_write(REG_LOOP_LENGTH, {16'd0, len});
      if ($urandom_range(0, 1) == 1) begin
        r = $urandom_range(0, 99);
        cfg_write(REG_MATCH_TAG, r < 15 ? 32'h00 : r < 30 ? 32'hFF : $urandom_range(0, 255));
      end
      repeat ($urandom_range(1, 4)) run_loop(len == 16'hFFFF ? $urandom_range(20, 200) : 700);
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.due_words.size() == 0) begin
      $display("descriptor_loop_tlv_parser_top regression: pass");
    end else begin
      $display("descriptor_loop_tlv_parser_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("descriptor_loop_tlv_parser_top regression: fail");
    $finish;
  end

endmodule
